@@ hw/rtl/ccbe_pkg.sv @@
// Package for the classical cipher byte engine.
// Holds register indexes, mode codes, ASCII bounds and the config bundle type.
// No dependencies.
package ccbe_pkg;

  localparam int unsigned KeyW       = 31;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned NumLetters = 26;
  localparam int unsigned OffW       = 5;
  localparam int unsigned K10W       = 4;
  localparam int unsigned K26W       = 5;

  typedef enum logic [CfgIdxW-1:0] {
    RegMode     = 3'd0,
    RegShiftKey = 3'd1,
    RegTable0   = 3'd2,
    RegTable1   = 3'd3,
    RegTable2   = 3'd4,
    RegTable3   = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ModeCaesarEnc = 2'd0,
    ModeCaesarDec = 2'd1,
    ModeSubstEnc  = 2'd2,
    ModeSubstDec  = 2'd3
  } mode_e;

  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowZ   = 8'h7a;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5a;

  localparam logic [OffW-1:0] SizeDigits  = 5'd10;
  localparam logic [OffW-1:0] SizeLetters = 5'd26;

  typedef logic [NumLetters-1:0][7:0] tbl_t;

  typedef struct packed {
    mode_e            mode;
    logic [K10W-1:0]  k10;
    logic [K26W-1:0]  k26;
    tbl_t             tbl;
  } cfg_t;

endpackage

@@ hw/rtl/classical_cipher_byte_engine_core.sv @@
// An input beat reaches the output beat through two registers (input reg, result reg).
// Throughput: one byte per cycle when not stalled; the transform is a single pass between them.
// A shift_key write reduces the key mod 10 / mod 26 in a two-stage reciprocal
// multiplier; in_stall_o is held high while that reduction is busy after the write.
// Reset clears all config registers to 0 and empties the pipeline.
module classical_cipher_byte_engine_core import ccbe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          byte_in_i,
  input  logic                last_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          byte_out_o,
  output logic                last_out_o
);

  mode_e        mode_q, mode_d;
  logic [63:0]  tw0_q, tw0_d, tw1_q, tw1_d, tw2_q, tw2_d;
  logic [15:0]  tw3_q, tw3_d;
  logic         key_load, key_busy;
  logic [K10W-1:0] k10;
  logic [K26W-1:0] k26;
  cfg_t         cfg;

  logic         s1_valid_q, s1_valid_d;
  logic [7:0]   s1_byte_q;
  logic         s1_last_q;
  logic         out_valid_q, out_valid_d;
  logic [7:0]   out_byte_q;
  logic         out_last_q;
  logic [7:0]   xf_byte;
  logic         out_adv, s1_adv, in_beat;

  always_comb begin
    mode_d   = mode_q;
    tw0_d    = tw0_q;
    tw1_d    = tw1_q;
    tw2_d    = tw2_q;
    tw3_d    = tw3_q;
    key_load = 1'b0;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegMode:     mode_d   = mode_e'(cfg_wdata_i[1:0]);
        RegShiftKey: key_load = 1'b1;
        RegTable0:   tw0_d    = cfg_wdata_i;
        RegTable1:   tw1_d    = cfg_wdata_i;
        RegTable2:   tw2_d    = cfg_wdata_i;
        RegTable3:   tw3_d    = cfg_wdata_i[15:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeCaesarEnc;
      tw0_q  <= '0;
      tw1_q  <= '0;
      tw2_q  <= '0;
      tw3_q  <= '0;
    end else begin
      mode_q <= mode_d;
      tw0_q  <= tw0_d;
      tw1_q  <= tw1_d;
      tw2_q  <= tw2_d;
      tw3_q  <= tw3_d;
    end
  end

  ccbe_key_mod u_key_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (key_load),
    .key_i  (cfg_wdata_i[KeyW-1:0]),
    .busy_o (key_busy),
    .k10_o  (k10),
    .k26_o  (k26)
  );

  always_comb begin
    cfg.mode = mode_q;
    cfg.k10  = k10;
    cfg.k26  = k26;
    for (int i = 0; i < 8; i++) begin
      cfg.tbl[i]      = tw0_q[8*i +: 8];
      cfg.tbl[8 + i]  = tw1_q[8*i +: 8];
      cfg.tbl[16 + i] = tw2_q[8*i +: 8];
    end
    cfg.tbl[24] = tw3_q[7:0];
    cfg.tbl[25] = tw3_q[15:8];
  end

  ccbe_xform u_xform (
    .cfg_i  (cfg),
    .byte_i (s1_byte_q),
    .byte_o (xf_byte)
  );

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_stall_o = key_busy || !s1_adv;
  assign in_beat    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = s1_adv ? in_beat : s1_valid_q;
  assign out_valid_d = out_adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_byte_q <= byte_in_i;
      s1_last_q <= last_in_i;
    end
    if (out_adv && s1_valid_q) begin
      out_byte_q <= xf_byte;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign byte_out_o  = out_byte_q;
  assign last_out_o  = out_last_q;

endmodule

@@ hw/rtl/ccbe_key_mod.sv @@
// Shift key reducer: key mod 10 and key mod 26 by reciprocal multiplication.
// After a load: key register, then quotient register, then remainder register.
// Depends on ccbe_pkg.
module ccbe_key_mod import ccbe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [KeyW-1:0]  key_i,
  output logic             busy_o,
  output logic [K10W-1:0]  k10_o,
  output logic [K26W-1:0]  k26_o
);

  localparam int unsigned Q10W = 28;
  localparam int unsigned Q26W = 27;
  localparam int unsigned P10W = 63;
  localparam int unsigned P13W = 61;
  // ceil(2^35 / 10) and ceil(2^34 / 13); exact over the whole key range
  localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;
  localparam logic [30:0] Recip13 = 31'h4EC4_EC4F;

  logic [KeyW-1:0] key_q, key_d;
  logic            qv_q, qv_d;
  logic            rv_q, rv_d;
  logic [P10W-1:0] p10;
  logic [P13W-1:0] p13;
  logic [Q10W-1:0] q10_q, q10_d;
  logic [Q26W-1:0] q26_q, q26_d;
  logic [KeyW-1:0] m10, m26;
  logic [K10W-1:0] r10_q, r10_d;
  logic [K26W-1:0] r26_q, r26_d;

  // key / 26 = (key / 2) / 13
  assign p10 = P10W'(key_q) * P10W'(Recip10);
  assign p13 = P13W'(key_q[KeyW-1:1]) * P13W'(Recip13);
  // 10q = 8q + 2q, 26q = 16q + 8q + 2q
  assign m10 = KeyW'({q10_q, 3'b0}) + KeyW'({q10_q, 1'b0});
  assign m26 = KeyW'({q26_q, 4'b0}) + KeyW'({q26_q, 3'b0}) + KeyW'({q26_q, 1'b0});

  always_comb begin
    key_d = load_i ? key_i : key_q;
    qv_d  = load_i;
    rv_d  = qv_q;
    q10_d = qv_q ? p10[P10W-1:35] : q10_q;
    q26_d = qv_q ? p13[P13W-1:34] : q26_q;
    r10_d = rv_q ? K10W'(key_q - m10) : r10_q;
    r26_d = rv_q ? K26W'(key_q - m26) : r26_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      qv_q  <= 1'b0;
      rv_q  <= 1'b0;
      q10_q <= '0;
      q26_q <= '0;
      r10_q <= '0;
      r26_q <= '0;
    end else begin
      key_q <= key_d;
      qv_q  <= qv_d;
      rv_q  <= rv_d;
      q10_q <= q10_d;
      q26_q <= q26_d;
      r10_q <= r10_d;
      r26_q <= r26_d;
    end
  end

  assign busy_o = qv_q || rv_q;
  assign k10_o  = r10_q;
  assign k26_o  = r26_q;

endmodule

@@ hw/rtl/ccbe_xform.sv @@
// Per-byte transform: Caesar rotate and substitution lookup / reverse search.
// Depends on ccbe_pkg.
module ccbe_xform import ccbe_pkg::*; (
  input  cfg_t        cfg_i,
  input  logic [7:0]  byte_i,
  output logic [7:0]  byte_o
);

  function automatic logic [OffW-1:0] rotate(input logic [OffW-1:0] off,
                                             input logic [OffW-1:0] amt,
                                             input logic [OffW-1:0] size,
                                             input logic            fwd);
    logic [OffW:0] s;
    begin
      if (fwd) s = {1'b0, off} + {1'b0, amt};
      else     s = {1'b0, off} + {1'b0, size} - {1'b0, amt};
      if (s >= {1'b0, size}) s = s - {1'b0, size};
      return s[OffW-1:0];
    end
  endfunction

  logic             fwd;
  logic             is_dig, is_low, is_up;
  logic [7:0]       caesar_b, subst_enc_b, subst_dec_b;
  logic [OffW-1:0]  k10_x, hit_idx;
  logic             hit;

  assign fwd    = (cfg_i.mode == ModeCaesarEnc);
  assign is_dig = (byte_i >= ChDigit0) && (byte_i <= ChDigit9);
  assign is_low = (byte_i >= ChLowA) && (byte_i <= ChLowZ);
  assign is_up  = (byte_i >= ChUpA) && (byte_i <= ChUpZ);
  assign k10_x  = {1'b0, cfg_i.k10};

  always_comb begin
    caesar_b = byte_i;
    if (is_dig) begin
      caesar_b = ChDigit0 + {3'b0, rotate(OffW'(byte_i - ChDigit0), k10_x, SizeDigits, fwd)};
    end else if (is_low) begin
      caesar_b = ChLowA + {3'b0, rotate(OffW'(byte_i - ChLowA), cfg_i.k26, SizeLetters, fwd)};
    end else if (is_up) begin
      caesar_b = ChUpA + {3'b0, rotate(OffW'(byte_i - ChUpA), cfg_i.k26, SizeLetters, fwd)};
    end
  end

  always_comb begin
    subst_enc_b = byte_i;
    if (is_low) begin
      subst_enc_b = cfg_i.tbl[OffW'(byte_i - ChLowA)];
    end
  end

  // descending scan so the lowest matching letter wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int j = NumLetters - 1; j >= 0; j--) begin
      if (cfg_i.tbl[j] == byte_i) begin
        hit     = 1'b1;
        hit_idx = OffW'(j);
      end
    end
    subst_dec_b = hit ? (ChLowA + {3'b0, hit_idx}) : byte_i;
  end

  always_comb begin
    unique case (cfg_i.mode)
      ModeCaesarEnc, ModeCaesarDec: byte_o = caesar_b;
      ModeSubstEnc:                 byte_o = subst_enc_b;
      ModeSubstDec:                 byte_o = subst_dec_b;
      default:                      byte_o = byte_i;
    endcase
  end

endmodule
